// File: src/cahcd_pkg.sv
// ----------------------------------------------------------------------------
// cahcd_pkg: shared constants and types for the cell average / hash detector
// Field widths, accumulator sizing, hash seed and finish-sequencer states.
// ----------------------------------------------------------------------------
package cahcd_pkg;

  // Cells with a stored previous brightness, and the per-cell pixel bound
  localparam int CELL_COUNT      = 1024;
  localparam int MAX_CELL_PIXELS = 2097152;

  localparam int CELL_AW  = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int TALLY_W  = $clog2(MAX_CELL_PIXELS + 1);
  localparam int PIX_W    = 8;
  localparam int PSUM_W   = PIX_W + 2;  // r + g + b of one pixel
  localparam int SUM_W    = TALLY_W + PIX_W;
  localparam int CELL_W   = 10;
  localparam int BRIGHT_W = 10;
  localparam int THRESH_W = 10;
  localparam int HASH_W   = 32;
  localparam int LANES    = 3;      // red, green, blue
  localparam int QUO_STEPS = PIX_W; // one quotient bit per divide step
  localparam int STEP_W   = $clog2(QUO_STEPS);

  localparam logic [HASH_W-1:0]   HASH_SEED    = 32'd5381;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd15;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_CMP
  } fin_state_e;

  // previous-frame entry: {known, brightness}
  typedef logic [BRIGHT_W:0] prev_entry_t;

endpackage

// File: src/cell_average_hash_change_detect.sv
// ----------------------------------------------------------------------------
// cell_average_hash_change_detect
// Per-cell channel averages, brightness, djb2-style hash and frame-to-frame
// brightness change against a per-cell store.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | beat
//  --------+-------------------------------------------+--------------------------
//  pixel   | in_valid_i / in_ready_o                   | one pixel + cell, last
//  config  | cfg_valid_i / cfg_ready_o                 | change threshold
//  result  | out_valid_o / out_ready_i                 | one result per cell
//
//  - A non-last pixel beat is taken every cycle once the store sweep is done.
//  - The last pixel hands the sums to a finish sequencer: restoring
//    division (three channel lanes side by side, one quotient bit each
//    per step), then the store read, then compare and write-back.
//    A further last pixel is held off until the sequencer is idle again;
//    ordinary pixels keep flowing.
//  - After reset the previous-frame store is swept once, one entry a cycle;
//    no pixel beat is taken until it is done.
//  - A stalled result sits in the output register; the sequencer waits in
//    the read state only while that register is still full.
//
module cell_average_hash_change_detect (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // pixel stream
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [cahcd_pkg::PIX_W-1:0]     pixel_blue_i,
  input  logic [cahcd_pkg::PIX_W-1:0]     pixel_green_i,
  input  logic [cahcd_pkg::PIX_W-1:0]     pixel_red_i,
  input  logic [cahcd_pkg::CELL_W-1:0]    cell_number_i,
  input  logic                            last_pixel_i,
  // configuration
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cahcd_pkg::THRESH_W-1:0]  cfg_change_threshold_i,
  // results
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [cahcd_pkg::CELL_W-1:0]    result_cell_o,
  output logic [cahcd_pkg::PIX_W-1:0]     average_red_o,
  output logic [cahcd_pkg::PIX_W-1:0]     average_green_o,
  output logic [cahcd_pkg::PIX_W-1:0]     average_blue_o,
  output logic [cahcd_pkg::BRIGHT_W-1:0]  brightness_times_three_o,
  output logic [cahcd_pkg::HASH_W-1:0]    cell_hash_o,
  output logic [cahcd_pkg::BRIGHT_W-1:0]  change_times_three_o,
  output logic                            changed_flag_o,
  output logic                            count_overflow_o
);
  import cahcd_pkg::*;

  // ---------------- configuration ----------------
  logic [THRESH_W-1:0] thresh_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (cfg_valid_i) begin
      thresh_q <= cfg_change_threshold_i;
    end
  end

  // ---------------- accumulation ----------------
  fin_state_e        state_q, state_d;
  logic              in_fire;
  logic              fin_load;

  logic [PIX_W-1:0]  pix [LANES];
  logic [SUM_W-1:0]  sum_q [LANES];
  logic [SUM_W-1:0]  sum_n [LANES];
  logic [TALLY_W-1:0] tally_q, tally_n;
  logic [HASH_W-1:0] hash_q, hash_n;
  logic              ovf_q, ovf_n;
  logic              below_bound;
  logic [PSUM_W-1:0] pix_total;

  assign pix[0] = pixel_red_i;
  assign pix[1] = pixel_green_i;
  assign pix[2] = pixel_blue_i;

  assign in_fire = in_valid_i & in_ready_o;

  always_comb begin
    pix_total   = PSUM_W'(pixel_red_i) + PSUM_W'(pixel_green_i) + PSUM_W'(pixel_blue_i);
    // hash * 33 as shift and add
    hash_n      = (hash_q << 5) + hash_q + HASH_W'(pix_total);
    below_bound = tally_q < TALLY_W'(MAX_CELL_PIXELS);
    for (int l = 0; l < LANES; l++) begin
      sum_n[l] = below_bound ? sum_q[l] + SUM_W'(pix[l]) : sum_q[l];
    end
    tally_n = below_bound ? tally_q + TALLY_W'(1) : tally_q;
    ovf_n   = ovf_q | ~below_bound;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LANES; l++) sum_q[l] <= '0;
      tally_q <= '0;
      hash_q  <= HASH_SEED;
      ovf_q   <= 1'b0;
    end else if (in_fire) begin
      if (last_pixel_i) begin
        for (int l = 0; l < LANES; l++) sum_q[l] <= '0;
        tally_q <= '0;
        hash_q  <= HASH_SEED;
        ovf_q   <= 1'b0;
      end else begin
        for (int l = 0; l < LANES; l++) sum_q[l] <= sum_n[l];
        tally_q <= tally_n;
        hash_q  <= hash_n;
        ovf_q   <= ovf_n;
      end
    end
  end

  // ---------------- finish: division lanes ----------------
  // Quotient fits PIX_W bits since sum <= 255 * tally.
  logic [SUM_W-1:0]  rem_q [LANES];
  logic [PIX_W-1:0]  quo_q [LANES];
  logic [SUM_W-1:0]  div_q;
  logic [HASH_W-1:0] fin_hash_q;
  logic              fin_ovf_q;
  logic [CELL_W-1:0] fin_cell_q;
  logic [STEP_W-1:0] step_q;

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      for (int l = 0; l < LANES; l++) begin
        rem_q[l] <= sum_n[l];
        quo_q[l] <= '0;
      end
      div_q      <= SUM_W'(tally_n) << (QUO_STEPS - 1);
      fin_hash_q <= hash_n;
      fin_ovf_q  <= ovf_n;
      fin_cell_q <= cell_number_i;
    end else if (state_q == ST_DIV) begin
      for (int l = 0; l < LANES; l++) begin
        if (rem_q[l] >= div_q) begin
          rem_q[l] <= rem_q[l] - div_q;
          quo_q[l] <= {quo_q[l][PIX_W-2:0], 1'b1};
        end else begin
          quo_q[l] <= {quo_q[l][PIX_W-2:0], 1'b0};
        end
      end
      div_q <= div_q >> 1;
    end
  end

  // ---------------- previous-frame store ----------------
  logic [31:0]        cell_ext;
  logic [CELL_AW-1:0] fin_addr;
  logic               cell_in_range;
  logic [CELL_AW-1:0] clr_addr_q;
  logic               mem_we, mem_re;
  logic [CELL_AW-1:0] mem_waddr;
  prev_entry_t        mem_wdata;
  prev_entry_t        mem_rdata_q;
  prev_entry_t        prev_mem [CELL_COUNT];

  assign cell_ext      = 32'(fin_cell_q);
  assign fin_addr      = cell_ext[CELL_AW-1:0];
  assign cell_in_range = cell_ext < 32'(CELL_COUNT);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      prev_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= prev_mem[fin_addr];
    end
  end

  // ---------------- compare ----------------
  logic [BRIGHT_W-1:0] bright;
  logic [BRIGHT_W-1:0] old_bright;
  logic                old_known;
  logic [BRIGHT_W-1:0] diff;
  logic                changed;

  always_comb begin
    bright     = BRIGHT_W'(quo_q[0]) + BRIGHT_W'(quo_q[1]) + BRIGHT_W'(quo_q[2]);
    old_known  = mem_rdata_q[BRIGHT_W] & cell_in_range;
    old_bright = mem_rdata_q[BRIGHT_W-1:0];
    if (!old_known) begin
      diff = '0;
    end else if (bright >= old_bright) begin
      diff = bright - old_bright;
    end else begin
      diff = old_bright - bright;
    end
    changed = old_known & (diff > thresh_q);
  end

  assign mem_waddr = (state_q == ST_CLEAR) ? clr_addr_q : fin_addr;
  assign mem_wdata = (state_q == ST_CLEAR) ? prev_entry_t'(0) : {1'b1, bright};

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      step_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + CELL_AW'(1);
      end
      if (fin_load) begin
        step_q <= STEP_W'(QUO_STEPS - 1);
      end else if (state_q == ST_DIV) begin
        step_q <= step_q - STEP_W'(1);
      end
    end
  end

  logic out_valid_q;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    fin_load   = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr_q == CELL_AW'(CELL_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && last_pixel_i) begin
          fin_load = 1'b1;
          state_d  = ST_DIV;
        end
      end
      ST_DIV: begin
        in_ready_o = ~last_pixel_i;
        if (step_q == '0) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        in_ready_o = ~last_pixel_i;
        mem_re     = 1'b1;
        // output register must be free by the time we load it
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        in_ready_o = ~last_pixel_i;
        mem_we     = cell_in_range;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------- output register ----------------
  logic [CELL_W-1:0]   res_cell_q;
  logic [PIX_W-1:0]    res_avg_q [LANES];
  logic [BRIGHT_W-1:0] res_bright_q;
  logic [HASH_W-1:0]   res_hash_q;
  logic [BRIGHT_W-1:0] res_diff_q;
  logic                res_changed_q;
  logic                res_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_CMP) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CMP) begin
      res_cell_q    <= fin_cell_q;
      for (int l = 0; l < LANES; l++) res_avg_q[l] <= quo_q[l];
      res_bright_q  <= bright;
      res_hash_q    <= fin_hash_q;
      res_diff_q    <= diff;
      res_changed_q <= changed;
      res_ovf_q     <= fin_ovf_q;
    end
  end

  assign out_valid_o              = out_valid_q;
  assign result_cell_o            = res_cell_q;
  assign average_red_o            = res_avg_q[0];
  assign average_green_o          = res_avg_q[1];
  assign average_blue_o           = res_avg_q[2];
  assign brightness_times_three_o = res_bright_q;
  assign cell_hash_o              = res_hash_q;
  assign change_times_three_o     = res_diff_q;
  assign changed_flag_o           = res_changed_q;
  assign count_overflow_o         = res_ovf_q;

endmodule

// File: src/cahcd_checker.sv
// ----------------------------------------------------------------------------
// cahcd_checker: port-level checks for cell_average_hash_change_detect
// Result stability under stall and consistency of the result fields.
// ----------------------------------------------------------------------------
module cahcd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [cahcd_pkg::CELL_W-1:0]    result_cell_o,
  input logic [cahcd_pkg::PIX_W-1:0]     average_red_o,
  input logic [cahcd_pkg::PIX_W-1:0]     average_green_o,
  input logic [cahcd_pkg::PIX_W-1:0]     average_blue_o,
  input logic [cahcd_pkg::BRIGHT_W-1:0]  brightness_times_three_o,
  input logic [cahcd_pkg::BRIGHT_W-1:0]  change_times_three_o,
  input logic                            changed_flag_o
);
  import cahcd_pkg::*;

  // stalled result beat holds its cell number and brightness
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_cell_o)
      && $stable(brightness_times_three_o))
    else $error("result beat changed while stalled");

  // brightness is the sum of the three averages
  a_bright_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> brightness_times_three_o ==
      BRIGHT_W'(average_red_o) + BRIGHT_W'(average_green_o) + BRIGHT_W'(average_blue_o))
    else $error("brightness does not match averages");

  // a flagged change has a nonzero difference
  a_flag_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && changed_flag_o |-> change_times_three_o != '0)
    else $error("change flagged with zero difference");

  // difference stays within the brightness range
  a_diff_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> change_times_three_o <= BRIGHT_W'(765))
    else $error("difference out of range");

endmodule

bind cell_average_hash_change_detect cahcd_checker u_cahcd_checker (
  .clk_i                    (clk_i),
  .rst_ni                   (rst_ni),
  .out_valid_o              (out_valid_o),
  .out_ready_i              (out_ready_i),
  .result_cell_o            (result_cell_o),
  .average_red_o            (average_red_o),
  .average_green_o          (average_green_o),
  .average_blue_o           (average_blue_o),
  .brightness_times_three_o (brightness_times_three_o),
  .change_times_three_o     (change_times_three_o),
  .changed_flag_o           (changed_flag_o)
);
